// ===== hw/rtl/gmaf_pkg.sv =====
// Shared constants, types and register codes for the gated median / average filter.
// Used by the channel interfaces, gmaf_median, gmaf_average and the top level.
`timescale 1ns / 1ps

package gmaf_pkg;

  // Filter geometry.
  localparam int unsigned AXES         = 3;
  localparam int unsigned MEDIAN_TAPS  = 7;
  localparam int unsigned AVERAGE_TAPS = 10;
  localparam int unsigned MEDIAN_RANK  = MEDIAN_TAPS / 2;
  localparam int unsigned MED_SLOT_W   = $clog2(MEDIAN_TAPS);
  localparam int unsigned AVG_SLOT_W   = $clog2(AVERAGE_TAPS);

  // Field widths.
  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned JUMP_W  = 31;
  localparam int unsigned DECAY_W = 32;
  localparam int unsigned SUM_W   = 36;

  // Division of the running sum by the tap count: multiply by a truncated
  // reciprocal scaled by 2^DIV_SHIFT, then one correction step.
  localparam int unsigned DIV_SHIFT = 38;
  localparam int unsigned DIV_LO_W  = 18;
  localparam int unsigned DIV_HI_W  = DIV_SHIFT - DIV_LO_W;
  localparam logic [DIV_SHIFT-1:0] DIV_MULT =
      DIV_SHIFT'((64'd1 << DIV_SHIFT) / AVERAGE_TAPS);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MS   = 2'd1;
  localparam logic [JUMP_W-1:0]    JUMP_LIMIT_RST = 31'd32768;
  localparam logic [DECAY_W-1:0]   DECAY_MS_RST   = 32'd2000;

  // Pipeline stage positions.
  localparam int unsigned ST_IN      = 0;
  localparam int unsigned ST_MED     = 1;
  localparam int unsigned ST_SUM     = 2;
  localparam int unsigned ST_MAG     = 3;
  localparam int unsigned ST_PROD    = 4;
  localparam int unsigned ST_QUOT    = 5;
  localparam int unsigned ST_OUT     = 6;
  localparam int unsigned PIPE_DEPTH = ST_OUT + 1;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [JUMP_W-1:0]  jump_limit;
    logic [DECAY_W-1:0] decay_ms;
  } cfg_t;

  // Stage load strobes issued by the top-level pipeline control.
  typedef struct packed {
    logic load_med;
    logic load_sum;
    logic load_mag;
    logic load_prod;
    logic load_quot;
    logic load_out;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/gmaf_if.sv =====
// Valid/ready channel interfaces of the filter: samples in, results out, register writes.
// Depends on gmaf_pkg for field widths.
`timescale 1ns / 1ps

interface gmaf_sample_if;
  logic                                valid;
  logic                                ready;
  logic [gmaf_pkg::TIME_W-1:0]         time_ms;
  logic signed [gmaf_pkg::POS_W-1:0]   pos_x;
  logic signed [gmaf_pkg::POS_W-1:0]   pos_y;
  logic signed [gmaf_pkg::POS_W-1:0]   pos_z;
  logic                                bad_x;
  logic                                bad_y;
  logic                                bad_z;

  modport source (output valid, time_ms, pos_x, pos_y, pos_z, bad_x, bad_y, bad_z,
                  input ready);
  modport sink (input valid, time_ms, pos_x, pos_y, pos_z, bad_x, bad_y, bad_z,
                output ready);
endinterface

interface gmaf_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [gmaf_pkg::POS_W-1:0]   out_x;
  logic signed [gmaf_pkg::POS_W-1:0]   out_y;
  logic signed [gmaf_pkg::POS_W-1:0]   out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface gmaf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gmaf_pkg::CFG_IDX_W-1:0]      index;
  logic [gmaf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gmaf_median.sv =====
// Gated median stage of one axis: hold, jump rejection, decay restart and 7-tap median.
// Depends on gmaf_pkg; stepped by the load_med strobe from the top level.
`timescale 1ns / 1ps

module gmaf_median (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gmaf_pkg::pipe_ctl_t         ctl_i,
  input  gmaf_pkg::cfg_t              cfg_i,
  input  gmaf_pkg::pos_t              sample_i,
  input  logic                        bad_i,
  input  logic [gmaf_pkg::TIME_W-1:0] time_i,
  output gmaf_pkg::pos_t              med_o
);
  import gmaf_pkg::*;

  pos_t                ring_q [MEDIAN_TAPS];
  pos_t                ring_d [MEDIAN_TAPS];
  logic [MED_SLOT_W-1:0] slot_q, slot_d;
  pos_t                held_q, held_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;
  logic                started_q, started_d;
  pos_t                med_q, med_d;

  pos_t                cand [MEDIAN_TAPS];
  logic [MED_SLOT_W-1:0] rank [MEDIAN_TAPS];
  pos_t                cand_med;
  logic signed [POS_W:0] diff;
  logic [POS_W:0]      jump_mag;
  logic                jump_big;
  logic [TIME_W-1:0]   elapsed;
  logic                decayed;

  // Ring as it would look with the sample written at the current slot.
  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      cand[i] = (slot_q == MED_SLOT_W'(i)) ? sample_i : ring_q[i];
    end
  end

  // Rank of each entry in sorted order; ties are broken by position so that
  // exactly one entry lands on the middle rank.
  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i) begin
          if ((cand[j] < cand[i]) || ((cand[j] == cand[i]) && (j < i))) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
    end
    cand_med = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (rank[i] == MED_SLOT_W'(MEDIAN_RANK)) begin
        cand_med = cand[i];
      end
    end
  end

  // Exact distance from the held value and the age of the last accepted sample.
  always_comb begin
    diff     = {sample_i[POS_W-1], sample_i} - {held_q[POS_W-1], held_q};
    jump_mag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
    jump_big = jump_mag > (POS_W+1)'(cfg_i.jump_limit);
    elapsed  = time_i - stamp_q;
    decayed  = elapsed > cfg_i.decay_ms;
  end

  // Next state, in order of priority: invalid, unstarted, jump, accepted.
  always_comb begin
    ring_d    = ring_q;
    slot_d    = slot_q;
    held_d    = held_q;
    stamp_d   = stamp_q;
    started_d = started_q;
    med_d     = held_q;
    if (bad_i) begin
      med_d = held_q;
    end else if (!started_q) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        ring_d[i] = sample_i;
      end
      held_d    = sample_i;
      stamp_d   = time_i;
      started_d = 1'b1;
      med_d     = sample_i;
    end else if (jump_big) begin
      if (decayed) begin
        for (int i = 0; i < MEDIAN_TAPS; i++) begin
          ring_d[i] = '0;
        end
        slot_d    = '0;
        held_d    = '0;
        stamp_d   = time_i;
        started_d = 1'b0;
        med_d     = sample_i;
      end else begin
        med_d = held_q;
      end
    end else begin
      ring_d  = cand;
      slot_d  = (slot_q == MED_SLOT_W'(MEDIAN_TAPS - 1)) ? '0 : slot_q + 1'b1;
      held_d  = cand_med;
      stamp_d = time_i;
      med_d   = cand_med;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      held_q    <= '0;
      stamp_q   <= '0;
      started_q <= 1'b0;
    end else if (ctl_i.load_med) begin
      slot_q    <= slot_d;
      held_q    <= held_d;
      stamp_q   <= stamp_d;
      started_q <= started_d;
    end
  end

  // Ring contents and stage output; the ring is always filled before it is read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_med) begin
      ring_q <= ring_d;
      med_q  <= med_d;
    end
  end

  assign med_o = med_q;

  // A stopped median stage always restarts at the first slot.
  a_unstarted_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !started_q |-> (slot_q == '0))
    else $error("median slot moved while the stage is unstarted");

  // An invalid sample leaves the held value untouched.
  a_bad_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ctl_i.load_med && bad_i) |=> (held_q == $past(held_q)))
    else $error("invalid sample changed the held value");

endmodule

// ===== hw/rtl/gmaf_average.sv =====
// Moving average stage of one axis: 10-tap ring with running sum and a pipelined
// divide by the tap count. Depends on gmaf_pkg; stepped by the top-level strobes.
`timescale 1ns / 1ps

module gmaf_average (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmaf_pkg::pipe_ctl_t ctl_i,
  input  gmaf_pkg::pos_t      med_i,
  output gmaf_pkg::pos_t      avg_o
);
  import gmaf_pkg::*;

  localparam int unsigned PLO_W  = SUM_W + DIV_LO_W;
  localparam int unsigned PHI_W  = SUM_W + DIV_HI_W;
  localparam int unsigned PROD_W = SUM_W + DIV_SHIFT;

  pos_t                    ring_q [AVERAGE_TAPS];
  logic [AVG_SLOT_W-1:0]   slot_q, slot_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    started_q;
  logic signed [SUM_W-1:0] med_ext, old_ext;

  logic [SUM_W-1:0]        mag_q, mag_d;
  logic                    neg_q;
  logic [PLO_W-1:0]        plo_q;
  logic [PHI_W-1:0]        phi_q;
  logic [SUM_W-1:0]        mag4_q;
  logic                    neg4_q;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        quo_q, quo_d;
  logic [SUM_W-1:0]        mag5_q;
  logic                    neg5_q;
  logic [SUM_W-1:0]        tenq, rem, rem_fix, quo_fix;
  logic                    fix;
  logic [POS_W-1:0]        qlow;
  pos_t                    out_q, out_d;

  // Running sum update; a fresh stage fills the ring with the first value.
  always_comb begin
    med_ext = {{(SUM_W-POS_W){med_i[POS_W-1]}}, med_i};
    old_ext = {{(SUM_W-POS_W){ring_q[slot_q][POS_W-1]}}, ring_q[slot_q]};
    if (!started_q) begin
      sum_d  = med_ext * $signed(SUM_W'(AVERAGE_TAPS));
      slot_d = slot_q;
    end else begin
      sum_d  = sum_q - old_ext + med_ext;
      slot_d = (slot_q == AVG_SLOT_W'(AVERAGE_TAPS - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      started_q <= 1'b0;
    end else if (ctl_i.load_sum) begin
      slot_q    <= slot_d;
      started_q <= 1'b1;
    end
  end

  // The sum register doubles as the payload of the sum stage.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_sum) begin
      sum_q <= sum_d;
      if (!started_q) begin
        for (int i = 0; i < AVERAGE_TAPS; i++) begin
          ring_q[i] <= med_i;
        end
      end else begin
        ring_q[slot_q] <= med_i;
      end
    end
  end

  // Sign and magnitude of the sum.
  assign mag_d = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Reciprocal products, then their sum shifted down, then one correction.
  always_comb begin
    prod    = {phi_q, {DIV_LO_W{1'b0}}} + PROD_W'(plo_q);
    quo_d   = prod[PROD_W-1:DIV_SHIFT];
    tenq    = SUM_W'(quo_q * SUM_W'(AVERAGE_TAPS));
    rem     = mag5_q - tenq;
    fix     = rem >= SUM_W'(AVERAGE_TAPS);
    rem_fix = fix ? rem - SUM_W'(AVERAGE_TAPS) : rem;
    quo_fix = quo_q + SUM_W'(fix);
    qlow    = quo_fix[POS_W-1:0];
    out_d   = neg5_q ? $signed(-qlow) : $signed(qlow);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_mag) begin
      mag_q <= mag_d;
      neg_q <= sum_q[SUM_W-1];
    end
    if (ctl_i.load_prod) begin
      plo_q  <= PLO_W'(mag_q) * PLO_W'(DIV_MULT[DIV_LO_W-1:0]);
      phi_q  <= PHI_W'(mag_q) * PHI_W'(DIV_MULT[DIV_SHIFT-1:DIV_LO_W]);
      mag4_q <= mag_q;
      neg4_q <= neg_q;
    end
    if (ctl_i.load_quot) begin
      quo_q  <= quo_d;
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
    end
    if (ctl_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign avg_o = out_q;

  // The estimated quotient is at most one short, so one correction suffices.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl_i.load_out |-> (rem_fix < SUM_W'(AVERAGE_TAPS)))
    else $error("divide correction left a remainder of a full tap count");

  // The ring slot only moves once the stage has started.
  a_unstarted_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !started_q |-> (slot_q == '0))
    else $error("average slot moved while the stage is unstarted");

endmodule

// ===== hw/rtl/gated_median_average_filter.sv =====
// Gated median / moving average position filter, three axes; uses gmaf_pkg, gmaf_if,
// gmaf_median and gmaf_average. A sample beat passes the input, median, sum,
// magnitude, product, quotient and output registers before its result beat is
// offered. Throughput: one sample per cycle while results are taken; each stage
// loads when empty or draining, so input is taken while a result waits if some
// stage is empty. Reset clears all valid bits, both filter stages to unstarted
// and the registers to 0.5 m and 2000 ms.
`timescale 1ns / 1ps

module gated_median_average_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  gmaf_sample_if.sink    sample_i,
  gmaf_cfg_if.sink       cfg_i,
  gmaf_result_if.source  result_o
);
  import gmaf_pkg::*;

  logic [PIPE_DEPTH-1:0] valid_q, valid_d;
  logic [PIPE_DEPTH:0]   stage_rdy;
  pipe_ctl_t             ctl;
  cfg_t                  cfg_q, cfg_d;

  logic [TIME_W-1:0]     time_q;
  pos_t                  pos_q [AXES];
  logic [AXES-1:0]       bad_q;
  pos_t                  pos_in [AXES];
  logic [AXES-1:0]       bad_in;
  pos_t                  avg [AXES];

  // Each stage can take a beat when it is empty or its beat moves on.
  always_comb begin
    stage_rdy[PIPE_DEPTH] = result_o.ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (stage_rdy[k]) begin
        valid_d[k] = (k == 0) ? sample_i.valid : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_comb begin
    ctl.load_med  = valid_q[ST_IN]   && stage_rdy[ST_MED];
    ctl.load_sum  = valid_q[ST_MED]  && stage_rdy[ST_SUM];
    ctl.load_mag  = valid_q[ST_SUM]  && stage_rdy[ST_MAG];
    ctl.load_prod = valid_q[ST_MAG]  && stage_rdy[ST_PROD];
    ctl.load_quot = valid_q[ST_PROD] && stage_rdy[ST_QUOT];
    ctl.load_out  = valid_q[ST_QUOT] && stage_rdy[ST_OUT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign sample_i.ready = stage_rdy[ST_IN];
  assign result_o.valid = valid_q[ST_OUT];

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_JUMP_LIMIT: cfg_d.jump_limit = cfg_i.data[JUMP_W-1:0];
        REG_DECAY_MS:   cfg_d.decay_ms   = cfg_i.data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_limit <= JUMP_LIMIT_RST;
      cfg_q.decay_ms   <= DECAY_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register.
  always_comb begin
    pos_in[0] = sample_i.pos_x;
    pos_in[1] = sample_i.pos_y;
    pos_in[2] = sample_i.pos_z;
    bad_in    = {sample_i.bad_z, sample_i.bad_y, sample_i.bad_x};
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      time_q <= sample_i.time_ms;
      pos_q  <= pos_in;
      bad_q  <= bad_in;
    end
  end

  // One median and one average stage per axis.
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    pos_t med;

    gmaf_median u_median (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .cfg_i    (cfg_q),
      .sample_i (pos_q[a]),
      .bad_i    (bad_q[a]),
      .time_i   (time_q),
      .med_o    (med)
    );

    gmaf_average u_average (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .med_i  (med),
      .avg_o  (avg[a])
    );
  end

  assign result_o.out_x = avg[0];
  assign result_o.out_y = avg[1];
  assign result_o.out_z = avg[2];

  // An empty input register never blocks a sample beat.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !valid_q[ST_IN] |-> sample_i.ready)
    else $error("input stalled with an empty input register");

  // A result beat that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (result_o.valid && !result_o.ready) |=>
      (result_o.valid && $stable(result_o.out_x) && $stable(result_o.out_y) &&
       $stable(result_o.out_z)))
    else $error("result beat changed while it was waiting");

  // Register writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cfg_i.ready)
    else $error("configuration channel not ready");

endmodule

// ===== sim/tb_gated_median_average_filter.sv =====
// Self-checking testbench for gated_median_average_filter: directed samples, then random phases.
// Depends on gmaf_pkg and the gmaf_if interfaces; predicts each result beat bar checked rows.
`timescale 1ns / 1ps

module tb_gated_median_average_filter;
  import gmaf_pkg::*;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int     DRAIN_CYCLES  = 4 * PIPE_DEPTH;
  localparam int     RANDOM_PHASES = 6;
  localparam int     PHASE_ITEMS   = 225;
  localparam int     MAX_REPORTS   = 10;
  localparam int     N_DIRECTED    = 13;
  localparam longint POS_MAX       = 64'sd2147483647;
  localparam longint POS_MIN       = -64'sd2147483648;

  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [AXES-1:0][POS_W-1:0] triple_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    triple_t           pos;
    logic [AXES-1:0]   bad;
  } sample_t;

  // One directed row; bad_xyz holds x in its top bit. The expected triple is
  // only used where check is set.
  typedef struct packed {
    logic [TIME_W-1:0] t;
    pos_t              x;
    pos_t              y;
    pos_t              z;
    logic [2:0]        bad_xyz;
    bit                check;
    pos_t              ex;
    pos_t              ey;
    pos_t              ez;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady = 1'b0;
  int   mismatch_count = 0;
  int   stall_left = 0;

  triple_t due_positions [$];
  string   axis_name [AXES] = '{"x", "y", "z"};

  // Per-axis copy of the filter state and the two registers.
  pos_t              med_ring [AXES][MEDIAN_TAPS];
  int unsigned       med_slot [AXES];
  pos_t              held_val [AXES];
  logic [TIME_W-1:0] held_ms [AXES];
  bit                med_live [AXES];
  pos_t              avg_ring [AXES][AVERAGE_TAPS];
  int unsigned       avg_slot [AXES];
  longint            avg_total [AXES];
  bit                avg_live [AXES];
  logic [JUMP_W-1:0]  jump_lim;
  logic [DECAY_W-1:0] decay_lim;

  // Random walk state for well-formed sample streams.
  longint            track [AXES];
  logic [TIME_W-1:0] sim_ms;

  // Reset values: after reset, held, unchanged through the bad flags; a jump of
  // exactly the jump limit is taken, one more is refused; an idle time of exactly
  // decay_ms does not restart; then decay, restart, wrap of the timestamp.
  row_t directed_rows [N_DIRECTED] = '{
    '{32'd100,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 3'b000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'd110,  32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 3'b111, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'd120,  32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 3'b000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'd130,  32'h7FFF_8000, 32'h8000_8000, 32'h0000_8001, 3'b000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'd2130, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 3'b000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'd2131, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 3'b000, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'd2140, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 3'b000, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'd2150, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000, 3'b101, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'hFFFF_FFF0, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_0001, 3'b010, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'h0000_0005, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8002, 3'b000, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'h0000_0800, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 3'b000, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 3'b000, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 3'b111, 1'b0,
      32'h0, 32'h0, 32'h0}
  };

  gmaf_sample_if smp ();
  gmaf_result_if res ();
  gmaf_cfg_if    cfg ();

  gated_median_average_filter u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (smp),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always #5 clk = ~clk;

  // Puts the filter state and registers back to their values after reset.
  function automatic void filter_reset();
    int a;
    int i;
    jump_lim  = JUMP_LIMIT_RST;
    decay_lim = DECAY_MS_RST;
    for (a = 0; a < AXES; a++) begin
      for (i = 0; i < MEDIAN_TAPS; i++) med_ring[a][i] = '0;
      for (i = 0; i < AVERAGE_TAPS; i++) avg_ring[a][i] = '0;
      med_slot[a]  = 0;
      held_val[a]  = '0;
      held_ms[a]   = '0;
      med_live[a]  = 1'b0;
      avg_slot[a]  = 0;
      avg_total[a] = 0;
      avg_live[a]  = 1'b0;
    end
  endfunction

  function automatic void reg_write_model(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
    if (idx == REG_JUMP_LIMIT) begin
      jump_lim = value[JUMP_W-1:0];
    end else if (idx == REG_DECAY_MS) begin
      decay_lim = value[DECAY_W-1:0];
    end
  endfunction

  // Gated median stage of one axis; returns the value passed to the average.
  function automatic pos_t median_step(int a, pos_t s, logic bad, logic [TIME_W-1:0] now);
    pos_t              sorted [MEDIAN_TAPS];
    pos_t              key;
    longint            delta;
    logic [TIME_W-1:0] idle_ms;
    int                i;
    int                j;
    if (bad) return held_val[a];
    if (!med_live[a]) begin
      for (i = 0; i < MEDIAN_TAPS; i++) med_ring[a][i] = s;
      held_val[a] = s;
      held_ms[a]  = now;
      med_live[a] = 1'b1;
      return s;
    end
    delta = longint'(s) - longint'(held_val[a]);
    if (delta < 0) delta = -delta;
    if (delta > longint'(jump_lim)) begin
      idle_ms = now - held_ms[a];
      if (idle_ms > decay_lim) begin
        // Too long without an accepted sample: restart and pass the raw value.
        for (i = 0; i < MEDIAN_TAPS; i++) med_ring[a][i] = '0;
        med_slot[a] = 0;
        held_val[a] = '0;
        held_ms[a]  = now;
        med_live[a] = 1'b0;
        return s;
      end
      return held_val[a];
    end
    med_ring[a][med_slot[a]] = s;
    med_slot[a] = (med_slot[a] + 1) % MEDIAN_TAPS;
    // Insertion sort of a copy of the ring.
    for (i = 0; i < MEDIAN_TAPS; i++) sorted[i] = med_ring[a][i];
    for (i = 1; i < MEDIAN_TAPS; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    held_val[a] = sorted[MEDIAN_RANK];
    held_ms[a]  = now;
    return held_val[a];
  endfunction

  // Moving average of one axis; the division truncates toward zero.
  function automatic pos_t average_step(int a, pos_t v);
    longint quot;
    int     i;
    if (!avg_live[a]) begin
      for (i = 0; i < AVERAGE_TAPS; i++) avg_ring[a][i] = v;
      avg_total[a] = longint'(v) * longint'(AVERAGE_TAPS);
      avg_live[a]  = 1'b1;
      return v;
    end
    avg_total[a] = avg_total[a] - longint'(avg_ring[a][avg_slot[a]]) + longint'(v);
    avg_ring[a][avg_slot[a]] = v;
    avg_slot[a] = (avg_slot[a] + 1) % AVERAGE_TAPS;
    quot = avg_total[a] / longint'(AVERAGE_TAPS);
    return pos_t'(quot);
  endfunction

  function automatic triple_t filter_predict(sample_t item);
    triple_t filtered;
    int      a;
    for (a = 0; a < AXES; a++) begin
      filtered[a] = average_step(a, median_step(a, pos_t'(item.pos[a]), item.bad[a],
                                                item.time_ms));
    end
    return filtered;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Mostly a slow walk within the jump limit; the rest is bad flags, stray values,
  // spikes past the jump limit, relocations and idle stretches long enough to decay.
  function automatic sample_t random_sample();
    sample_t     item;
    int unsigned r;
    longint      step;
    longint      cap;
    int          a;
    r = $urandom_range(0, 99);
    if (r < 84) begin
      sim_ms += $urandom_range(1, 150);
    end else if (r < 92) begin
      sim_ms += decay_lim + $urandom_range(1, 40);
    end else if (r < 96) begin
      sim_ms = $urandom;
    end
    item.time_ms = sim_ms;
    cap = longint'(jump_lim) / 2;
    if (cap > (longint'(1) << 20)) cap = longint'(1) << 20;
    for (a = 0; a < AXES; a++) begin
      item.bad[a] = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        item.bad[a] = 1'b1;
        item.pos[a] = $urandom;
      end else if (r < 10) begin
        item.pos[a] = $urandom;
      end else if (r < 16) begin
        step = longint'(jump_lim) + longint'($urandom_range(1, 1 << 18));
        if ($urandom_range(0, 1) == 1) step = -step;
        item.pos[a] = POS_W'(clamp_pos(track[a] + step));
      end else if (r < 19) begin
        case ($urandom_range(0, 2))
          0:       track[a] = POS_MAX;
          1:       track[a] = POS_MIN;
          default: track[a] = longint'($signed($urandom));
        endcase
        item.pos[a] = POS_W'(track[a]);
      end else begin
        step = longint'($urandom_range(0, 32'(cap)));
        if ($urandom_range(0, 1) == 1) step = -step;
        track[a] = clamp_pos(track[a] + step);
        item.pos[a] = POS_W'(track[a]);
      end
    end
    return item;
  endfunction

  // Offers one sample beat after a random gap and returns at the edge that takes it.
  task automatic send_sample(sample_t item);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid   <= 1'b1;
    smp.time_ms <= item.time_ms;
    smp.pos_x   <= item.pos[0];
    smp.pos_y   <= item.pos[1];
    smp.pos_z   <= item.pos[2];
    smp.bad_x   <= item.bad[0];
    smp.bad_y   <= item.bad[1];
    smp.bad_z   <= item.bad[2];
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    reg_write_model(idx, value);
  endtask

  // Stops offering samples and waits for every expected result beat.
  task automatic drain_results();
    smp.valid <= 1'b0;
    while (due_positions.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted beat, then decide the next ready.
  always @(posedge clk) begin
    triple_t     seen;
    triple_t     want;
    int unsigned n;
    int          a;
    if (rst_n && res.valid && res.ready) begin
      seen = {res.out_z, res.out_y, res.out_x};
      if (due_positions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: x=%h y=%h z=%h", seen[0], seen[1], seen[2]);
      end else begin
        want = due_positions.pop_front();
        for (a = 0; a < AXES; a++) begin
          if (seen[a] !== want[a]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("out_%s mismatch: expected %h, got %h", axis_name[a], want[a],
                       seen[a]);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else begin
      n = idle_cycles();
      if (n == 0) begin
        res.ready <= 1'b1;
      end else begin
        stall_left = n - 1;
        res.ready <= 1'b0;
      end
    end
  end

  // Stimulus: reset, the directed rows, then random phases under several settings.
  initial begin
    sample_t item;
    row_t    row;
    triple_t predicted;
    int      p;
    int      n;
    rst_n       = 1'b0;
    smp.valid   = 1'b0;
    smp.time_ms = '0;
    smp.pos_x   = '0;
    smp.pos_y   = '0;
    smp.pos_z   = '0;
    smp.bad_x   = 1'b0;
    smp.bad_y   = 1'b0;
    smp.bad_z   = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    res.ready   = 1'b0;
    sim_ms      = '0;
    for (n = 0; n < AXES; n++) track[n] = 0;
    filter_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      item.time_ms = row.t;
      item.pos     = {row.z, row.y, row.x};
      item.bad     = {row.bad_xyz[0], row.bad_xyz[1], row.bad_xyz[2]};
      send_sample(item);
      predicted = filter_predict(item);
      due_positions.push_back(row.check ? triple_t'({row.ez, row.ey, row.ex}) : predicted);
    end
    drain_results();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      // New register settings between phases, with the block idle.
      case (p)
        1: begin
          write_reg(REG_JUMP_LIMIT, 32'h0);
          write_reg(REG_DECAY_MS, 32'h0);
        end
        2: begin
          // Bit 31 of the jump limit write is dropped.
          write_reg(REG_JUMP_LIMIT, 32'hFFFF_FFFF);
          write_reg(REG_DECAY_MS, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_SPARE_A, $urandom);
          write_reg(REG_SPARE_B, $urandom);
          write_reg(REG_JUMP_LIMIT, $urandom_range(0, 32'h0004_0000));
          write_reg(REG_DECAY_MS, $urandom_range(0, 3000));
        end
        4: begin
          write_reg(REG_JUMP_LIMIT, $urandom);
          write_reg(REG_DECAY_MS, $urandom_range(0, 5000));
        end
        5: begin
          write_reg(REG_JUMP_LIMIT, CFG_DATA_W'(JUMP_LIMIT_RST));
          write_reg(REG_DECAY_MS, DECAY_MS_RST);
        end
        default: ;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 75 == 0) steady <= ($urandom_range(0, 3) == 0);
        item = random_sample();
        send_sample(item);
        due_positions.push_back(filter_predict(item));
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_gated_median_average_filter: PASS");
    end else begin
      $display("tb_gated_median_average_filter: FAIL");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #10_000_000;
    $display("tb_gated_median_average_filter: FAIL");
    $finish;
  end

endmodule
